>>> rtl/core/pid_incremental_controller_defines.svh
// ----------------------------------------------------------------------------
// PID incremental controller assertion macros
// Shared concurrent assertion shorthands, clocked on clock, off in reset.
// ----------------------------------------------------------------------------
`ifndef PID_INCREMENTAL_CONTROLLER_DEFINES_SVH
`define PID_INCREMENTAL_CONTROLLER_DEFINES_SVH

// same-cycle implication
`define PIDINC_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define PIDINC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/core/pidinc_pkg.sv
// ----------------------------------------------------------------------------
// pidinc_pkg
// Widths, register indexes and shared types of the incremental PID block.
// ----------------------------------------------------------------------------
package pidinc_pkg;

   localparam int GAIN_FRAC_BITS = 16;

   localparam int SAMPLE_W   = 16;
   localparam int ERR_W      = SAMPLE_W + 1;
   localparam int COEFF_W    = 32;
   localparam int LIMIT_W    = 17;
   localparam int DRIVE_W    = 17;
   localparam int PROD_W     = COEFF_W + ERR_W;
   localparam int SUM_W      = PROD_W + 3;
   localparam int LAST_W     = LIMIT_W + GAIN_FRAC_BITS + 1;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic signed [LIMIT_W-1:0] LIMIT_DEFAULT = 17'sh0FFFF;

   localparam logic [CSR_IDX_W-1:0] CSR_TARGET      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COEFF_NOW   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COEFF_PREV  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_COEFF_PREV2 = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_UPPER_LIMIT = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_LOWER_LIMIT = 3'd5;

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic signed [DRIVE_W-1:0]  drive_type;
   typedef logic signed [ERR_W-1:0]    err_type;
   typedef logic signed [PROD_W-1:0]   prod_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] target_value;
      logic signed [COEFF_W-1:0]  coeff_now;
      logic signed [COEFF_W-1:0]  coeff_prev;
      logic signed [COEFF_W-1:0]  coeff_prev2;
      logic signed [LIMIT_W-1:0]  upper_limit;
      logic signed [LIMIT_W-1:0]  lower_limit;
   } pidinc_cfg_type;

   typedef struct packed {
      prod_type p_now;
      prod_type p_prev;
      prod_type p_prev2;
   } pidinc_terms_type;

   typedef struct packed {
      logic full;
      logic empty;
   } pidinc_queue_status_type;

endpackage

>>> rtl/core/pidinc_req_if.sv
// ----------------------------------------------------------------------------
// pidinc_req_if
// Request channel: one measurement sample per request.
// ----------------------------------------------------------------------------
interface pidinc_req_if import pidinc_pkg::*; ();
   logic       valid;
   logic       ready;
   sample_type sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

>>> rtl/core/pidinc_rsp_if.sv
// ----------------------------------------------------------------------------
// pidinc_rsp_if
// Response channel: one clamped drive value per request.
// ----------------------------------------------------------------------------
interface pidinc_rsp_if import pidinc_pkg::*; ();
   logic      valid;
   logic      ready;
   drive_type drive;

   modport source (output valid, output drive, input ready);
   modport sink   (input valid, input drive, output ready);
endinterface

>>> rtl/core/pidinc_front.sv
// ----------------------------------------------------------------------------
// pidinc_front
// Accepts samples, forms the error, shifts the error history and computes
// the three gain products for the queue.
// ----------------------------------------------------------------------------
module pidinc_front import pidinc_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   pidinc_req_if.sink              req_ch,
   input  pidinc_cfg_type          cfg,
   input  pidinc_queue_status_type q_status,
   output logic                    push,
   output pidinc_terms_type        push_data
);

   err_type err;
   err_type err1_ff, err1_in;
   err_type err2_ff, err2_in;

   assign req_ch.ready = !q_status.full;
   assign push         = req_ch.valid && req_ch.ready;

   assign err = ERR_W'($signed(cfg.target_value)) - ERR_W'($signed(req_ch.sample));

   assign push_data.p_now   = PROD_W'($signed(cfg.coeff_now))   * PROD_W'(err);
   assign push_data.p_prev  = PROD_W'($signed(cfg.coeff_prev))  * PROD_W'(err1_ff);
   assign push_data.p_prev2 = PROD_W'($signed(cfg.coeff_prev2)) * PROD_W'(err2_ff);

   always_comb begin
      err1_in = err1_ff;
      err2_in = err2_ff;
      if (push) begin
         err1_in = err;
         err2_in = err1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         err1_ff <= '0;
         err2_ff <= '0;
      end else begin
         err1_ff <= err1_in;
         err2_ff <= err2_in;
      end
   end

endmodule

>>> rtl/core/pidinc_queue.sv
// ----------------------------------------------------------------------------
// pidinc_queue
// Short FIFO of product terms between the front and the back.
// ----------------------------------------------------------------------------
`include "pid_incremental_controller_defines.svh"

module pidinc_queue import pidinc_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  pidinc_terms_type        push_data,
   input  logic                    pop,
   output pidinc_terms_type        head,
   output pidinc_queue_status_type q_status
);

   pidinc_terms_type         entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]   count_ff, count_in;

   assign q_status.full  = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign q_status.empty = (count_ff == '0);
   assign head           = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = QUEUE_PTR_W'(wr_ptr_ff + 1'b1);
      end
      if (pop) begin
         rd_ptr_in = QUEUE_PTR_W'(rd_ptr_ff + 1'b1);
      end
      if (push && !pop) begin
         count_in = QUEUE_CNT_W'(count_ff + 1'b1);
      end else if (pop && !push) begin
         count_in = QUEUE_CNT_W'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   `PIDINC_ASSERT_NOW(a_no_push_full, q_status.full, !push, "push into full queue")
   `PIDINC_ASSERT_NOW(a_no_pop_empty, q_status.empty, !pop, "pop from empty queue")
   `PIDINC_ASSERT_NEXT(a_count_up, push && !pop, count_ff == QUEUE_CNT_W'($past(count_ff) + 1'b1), "queue count did not advance")

endmodule

>>> rtl/core/pidinc_back.sv
// ----------------------------------------------------------------------------
// pidinc_back
// Accumulates the products onto the last output, clamps to the limits and
// holds the result in the response register.
// ----------------------------------------------------------------------------
`include "pid_incremental_controller_defines.svh"

module pidinc_back import pidinc_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  pidinc_cfg_type          cfg,
   input  pidinc_terms_type        head,
   input  pidinc_queue_status_type q_status,
   output logic                    pop,
   pidinc_rsp_if.source            rsp_ch
);

   logic signed [SUM_W-1:0]  sum;
   logic signed [SUM_W-1:0]  hi_lim;
   logic signed [SUM_W-1:0]  lo_lim;
   logic signed [SUM_W-1:0]  clamp_hi;
   logic signed [SUM_W-1:0]  clamped;
   logic signed [LAST_W-1:0] last_ff, last_in;
   logic                     valid_ff, valid_in;
   drive_type                drive_ff, drive_in;

   assign pop = !q_status.empty && (!valid_ff || rsp_ch.ready);

   assign sum = SUM_W'(last_ff) + SUM_W'(head.p_now) + SUM_W'(head.p_prev)
              + SUM_W'(head.p_prev2);

   assign hi_lim = SUM_W'($signed(cfg.upper_limit)) <<< GAIN_FRAC_BITS;
   assign lo_lim = SUM_W'($signed(cfg.lower_limit)) <<< GAIN_FRAC_BITS;

   // upper clamp first, lower clamp wins when the limits cross
   assign clamp_hi = (sum > hi_lim) ? hi_lim : sum;
   assign clamped  = (clamp_hi < lo_lim) ? lo_lim : clamp_hi;

   always_comb begin
      last_in  = last_ff;
      drive_in = drive_ff;
      valid_in = valid_ff;
      if (pop) begin
         last_in  = clamped[LAST_W-1:0];
         drive_in = clamped[GAIN_FRAC_BITS +: DRIVE_W];
         valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         last_ff  <= last_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      drive_ff <= drive_in;
   end

   assign rsp_ch.valid = valid_ff;
   assign rsp_ch.drive = drive_ff;

   `PIDINC_ASSERT_NOW(a_clamp_range, pop && (lo_lim <= hi_lim),
      (clamped >= lo_lim) && (clamped <= hi_lim), "clamped value outside limits")
   `PIDINC_ASSERT_NEXT(a_load_valid, pop, valid_ff, "response not valid after load")

endmodule

>>> rtl/core/pid_incremental_controller.sv
// ----------------------------------------------------------------------------
// pid_incremental_controller
// Path: an accepted request is queued as products, then clamped into the response register.
// Throughput: one request per cycle while the response side accepts, set by the accumulate-and-clamp loop.
// Reset (synchronous): clears history and output, limits go to +/-65535.
// ----------------------------------------------------------------------------
module pid_incremental_controller import pidinc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   pidinc_req_if.sink            req_ch,
   pidinc_rsp_if.source          rsp_ch,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   pidinc_cfg_type          cfg_ff, cfg_in;
   pidinc_queue_status_type q_status;
   pidinc_terms_type        push_data;
   pidinc_terms_type        head;
   logic                    push;
   logic                    pop;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_TARGET:      cfg_in.target_value = csr_wdata[SAMPLE_W-1:0];
            CSR_COEFF_NOW:   cfg_in.coeff_now    = csr_wdata[COEFF_W-1:0];
            CSR_COEFF_PREV:  cfg_in.coeff_prev   = csr_wdata[COEFF_W-1:0];
            CSR_COEFF_PREV2: cfg_in.coeff_prev2  = csr_wdata[COEFF_W-1:0];
            CSR_UPPER_LIMIT: cfg_in.upper_limit  = csr_wdata[LIMIT_W-1:0];
            CSR_LOWER_LIMIT: cfg_in.lower_limit  = csr_wdata[LIMIT_W-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.target_value <= '0;
         cfg_ff.coeff_now    <= '0;
         cfg_ff.coeff_prev   <= '0;
         cfg_ff.coeff_prev2  <= '0;
         cfg_ff.upper_limit  <= LIMIT_DEFAULT;
         cfg_ff.lower_limit  <= -LIMIT_DEFAULT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   pidinc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .cfg       (cfg_ff),
      .q_status  (q_status),
      .push      (push),
      .push_data (push_data)
   );

   pidinc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head      (head),
      .q_status  (q_status)
   );

   pidinc_back u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .head     (head),
      .q_status (q_status),
      .pop      (pop),
      .rsp_ch   (rsp_ch)
   );

endmodule
